// ===== src/spi_nor_command_sequencer_core_assert.svh =====
// assertion macros for the command sequencer
`ifndef SPI_NOR_COMMAND_SEQUENCER_CORE_ASSERT_SVH
`define SPI_NOR_COMMAND_SEQUENCER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SNC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SNC_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SNC_ASSERT(label, clk, rst_n, prop, msg)
`define SNC_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== src/snc_pkg.sv =====
package snc_pkg;
    localparam int SectorBytes = 4096;
    localparam int SectorBits  = $clog2(SectorBytes);
    localparam int IdBytes     = 3;
    localparam int MaxRes      = 12;
    localparam int CntW        = $clog2(MaxRes + 1);
    localparam int QDepth      = 4;
    localparam int QPtrW       = $clog2(QDepth);

    typedef enum logic [1:0] {
        MODE_REQ  = 2'd0,
        MODE_HOST = 2'd1,
        MODE_RX   = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_PROG   = 3'd1,
        OP_SECTOR = 3'd2,
        OP_CHIP   = 3'd3,
        OP_ID     = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ACT_SEL   = 3'd0,
        ACT_SEND  = 3'd1,
        ACT_RECV  = 3'd2,
        ACT_DESEL = 3'd3,
        ACT_HOST  = 3'd4,
        ACT_DONE  = 3'd5
    } act_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_POLL     = 2'd1,
        PH_DATA_IN  = 2'd2,
        PH_DATA_OUT = 2'd3
    } phase_t;

    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_WRDI  = 8'h04;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_WRSR  = 8'h01;
    localparam logic [7:0] CMD_EWSR  = 8'h50;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_SE    = 8'h20;
    localparam logic [7:0] CMD_CE    = 8'hC7;
    localparam logic [7:0] CMD_PP    = 8'h02;
    localparam logic [7:0] CMD_RDID  = 8'h9F;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [15:0] POLL_LIMIT_RESET = 16'd10000;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] spi_byte;
        logic [7:0] host_byte;
        logic       status;
    } res_t;

    // one classified item: its whole result list
    typedef struct packed {
        logic [CntW-1:0]   count;
        res_t [MaxRes-1:0] res;
    } batch_t;

    function automatic res_t mk(input act_t a, input logic [7:0] sb,
                                input logic [7:0] hb, input logic st);
        res_t r;
        r.action = a;
        r.spi_byte = sb;
        r.host_byte = hb;
        r.status = st;
        return r;
    endfunction
endpackage

// ===== src/snc_if.sv =====
interface snc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [2:0]  operation;
    logic [23:0] address;
    logic [23:0] length;
    logic [7:0]  data_byte;
    modport source (output valid, mode, operation, address, length, data_byte, input ready);
    modport sink (input valid, mode, operation, address, length, data_byte, output ready);
endinterface

interface snc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] spi_byte;
    logic [7:0] host_byte;
    logic       status;
    logic       last;
    modport source (output valid, action, spi_byte, host_byte, status, last, input ready);
    modport sink (input valid, action, spi_byte, host_byte, status, last, output ready);
endinterface

// ===== src/snc_front.sv =====
module snc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,
    snc_in_if.sink        in_ch,
    input  logic          q_full,
    output logic          q_push,
    output snc_pkg::batch_t q_data
);
    import snc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  op_reg, op_next;
    logic [23:0] addr_reg, addr_next;
    logic [23:0] left_reg, left_next;
    logic [15:0] poll_reg, poll_next;
    logic [3:0]  step_reg, step_next;
    logic [15:0] limit_reg;
    logic        accept;
    batch_t      b;
    logic [23:0] left_dec;

    assign in_ch.ready = !q_full;
    assign accept = in_ch.valid && in_ch.ready;
    assign left_dec = (left_reg != 24'd0) ? left_reg - 24'd1 : left_reg;

    always_comb
    begin
        int n;
        n = 0;
        b = '0;
        phase_next = phase_reg;
        op_next = op_reg;
        addr_next = addr_reg;
        left_next = left_reg;
        poll_next = poll_reg;
        step_next = step_reg;
        case (in_ch.mode)
            MODE_REQ:
            begin
                if (phase_reg == PH_IDLE && in_ch.operation <= OP_ID)
                begin
                    op_next = in_ch.operation;
                    addr_next = in_ch.address;
                    left_next = in_ch.length;
                    if ((in_ch.operation == OP_READ || in_ch.operation == OP_PROG)
                        && in_ch.length == 24'd0)
                    begin
                        b.res[0] = mk(ACT_DONE, 8'd0, 8'd0, 1'b0); n = 1;
                    end
                    else if (in_ch.operation == OP_ID)
                    begin
                        left_next = 24'(IdBytes);
                        b.res[0] = mk(ACT_SEL, 8'd0, 8'd0, 1'b0);
                        b.res[1] = mk(ACT_SEND, CMD_RDID, 8'd0, 1'b0);
                        b.res[2] = mk(ACT_RECV, 8'd0, 8'd0, 1'b0);
                        n = 3;
                        phase_next = PH_DATA_IN;
                    end
                    else
                    begin
                        if (in_ch.operation == OP_SECTOR)
                            addr_next = {in_ch.address[23:SectorBits], SectorBits'(0)};
                        step_next = 4'd0;
                        poll_next = 16'd0;
                        b.res[0] = mk(ACT_SEL, 8'd0, 8'd0, 1'b0);
                        b.res[1] = mk(ACT_SEND, CMD_RDSR, 8'd0, 1'b0);
                        b.res[2] = mk(ACT_RECV, 8'd0, 8'd0, 1'b0);
                        n = 3;
                        phase_next = PH_POLL;
                    end
                end
            end
            MODE_HOST:
            begin
                if (phase_reg == PH_DATA_OUT)
                begin
                    b.res[0] = mk(ACT_SEND, in_ch.data_byte, 8'd0, 1'b0); n = 1;
                    left_next = left_dec;
                    if (left_dec == 24'd0)
                    begin
                        b.res[1] = mk(ACT_DESEL, 8'd0, 8'd0, 1'b0);
                        b.res[2] = mk(ACT_SEL, 8'd0, 8'd0, 1'b0);
                        b.res[3] = mk(ACT_SEND, CMD_RDSR, 8'd0, 1'b0);
                        b.res[4] = mk(ACT_RECV, 8'd0, 8'd0, 1'b0);
                        n = 5;
                        step_next = 4'd4;
                        poll_next = 16'd0;
                        phase_next = PH_POLL;
                    end
                end
            end
            MODE_RX:
            begin
                if (phase_reg == PH_DATA_IN)
                begin
                    b.res[0] = mk(ACT_HOST, 8'd0, in_ch.data_byte, 1'b0);
                    left_next = left_dec;
                    if (left_dec != 24'd0)
                    begin
                        b.res[1] = mk(ACT_RECV, 8'd0, 8'd0, 1'b0); n = 2;
                    end
                    else
                    begin
                        b.res[1] = mk(ACT_DESEL, 8'd0, 8'd0, 1'b0);
                        b.res[2] = mk(ACT_DONE, 8'd0, 8'd0, 1'b0);
                        n = 3;
                        phase_next = PH_IDLE;
                    end
                end
                else if (phase_reg == PH_POLL)
                begin
                    b.res[0] = mk(ACT_DESEL, 8'd0, 8'd0, 1'b0);
                    n = 1;
                    if (!in_ch.data_byte[0])
                    begin
                        // flash ready: next step of the operation
                        if (op_reg == OP_READ)
                        begin
                            b.res[1] = mk(ACT_SEL, 8'd0, 8'd0, 1'b0);
                            b.res[2] = mk(ACT_SEND, CMD_READ, 8'd0, 1'b0);
                            b.res[3] = mk(ACT_SEND, addr_reg[23:16], 8'd0, 1'b0);
                            b.res[4] = mk(ACT_SEND, addr_reg[15:8], 8'd0, 1'b0);
                            b.res[5] = mk(ACT_SEND, addr_reg[7:0], 8'd0, 1'b0);
                            b.res[6] = mk(ACT_RECV, 8'd0, 8'd0, 1'b0);
                            n = 7;
                            phase_next = PH_DATA_IN;
                        end
                        else if ((op_reg == OP_SECTOR || op_reg == OP_CHIP
                                  || op_reg == OP_PROG) && step_reg == 4'd1
                                 && op_reg != OP_PROG)
                        begin
                            b.res[1] = mk(ACT_SEL, 8'd0, 8'd0, 1'b0);
                            if (op_reg == OP_SECTOR)
                            begin
                                b.res[2] = mk(ACT_SEND, CMD_SE, 8'd0, 1'b0);
                                b.res[3] = mk(ACT_SEND, addr_reg[23:16], 8'd0, 1'b0);
                                b.res[4] = mk(ACT_SEND, addr_reg[15:8], 8'd0, 1'b0);
                                b.res[5] = mk(ACT_SEND, addr_reg[7:0], 8'd0, 1'b0);
                                n = 6;
                            end
                            else
                            begin
                                b.res[2] = mk(ACT_SEND, CMD_CE, 8'd0, 1'b0);
                                n = 3;
                            end
                            b.res[n]   = mk(ACT_DESEL, 8'd0, 8'd0, 1'b0);
                            b.res[n+1] = mk(ACT_SEL, 8'd0, 8'd0, 1'b0);
                            b.res[n+2] = mk(ACT_SEND, CMD_RDSR, 8'd0, 1'b0);
                            b.res[n+3] = mk(ACT_RECV, 8'd0, 8'd0, 1'b0);
                            n = n + 4;
                            step_next = 4'd2;
                            poll_next = 16'd0;
                        end
                        else if (op_reg == OP_PROG && step_reg == 4'd1)
                        begin
                            b.res[1] = mk(ACT_SEL, 8'd0, 8'd0, 1'b0);
                            b.res[2] = mk(ACT_SEND, CMD_WRSR, 8'd0, 1'b0);
                            b.res[3] = mk(ACT_SEND, BYTE_ZERO, 8'd0, 1'b0);
                            b.res[4] = mk(ACT_DESEL, 8'd0, 8'd0, 1'b0);
                            b.res[5] = mk(ACT_SEL, 8'd0, 8'd0, 1'b0);
                            b.res[6] = mk(ACT_SEND, CMD_RDSR, 8'd0, 1'b0);
                            b.res[7] = mk(ACT_RECV, 8'd0, 8'd0, 1'b0);
                            n = 8;
                            step_next = 4'd2;
                            poll_next = 16'd0;
                        end
                        else if (step_reg == 4'd0
                                 || (op_reg == OP_PROG && (step_reg == 4'd2
                                     || step_reg == 4'd4)))
                        begin
                            b.res[1] = mk(ACT_SEL, 8'd0, 8'd0, 1'b0);
                            if (op_reg == OP_PROG && step_reg == 4'd0)
                                b.res[2] = mk(ACT_SEND, CMD_EWSR, 8'd0, 1'b0);
                            else if (op_reg == OP_PROG && step_reg == 4'd4)
                                b.res[2] = mk(ACT_SEND, CMD_WRDI, 8'd0, 1'b0);
                            else
                                b.res[2] = mk(ACT_SEND, CMD_WREN, 8'd0, 1'b0);
                            b.res[3] = mk(ACT_DESEL, 8'd0, 8'd0, 1'b0);
                            b.res[4] = mk(ACT_SEL, 8'd0, 8'd0, 1'b0);
                            b.res[5] = mk(ACT_SEND, CMD_RDSR, 8'd0, 1'b0);
                            b.res[6] = mk(ACT_RECV, 8'd0, 8'd0, 1'b0);
                            n = 7;
                            step_next = step_reg + 4'd1;
                            poll_next = 16'd0;
                        end
                        else if (op_reg == OP_PROG && step_reg == 4'd3)
                        begin
                            b.res[1] = mk(ACT_SEL, 8'd0, 8'd0, 1'b0);
                            b.res[2] = mk(ACT_SEND, CMD_PP, 8'd0, 1'b0);
                            b.res[3] = mk(ACT_SEND, addr_reg[23:16], 8'd0, 1'b0);
                            b.res[4] = mk(ACT_SEND, addr_reg[15:8], 8'd0, 1'b0);
                            b.res[5] = mk(ACT_SEND, addr_reg[7:0], 8'd0, 1'b0);
                            n = 6;
                            phase_next = PH_DATA_OUT;
                        end
                        else
                        begin
                            b.res[1] = mk(ACT_DONE, 8'd0, 8'd0, 1'b0);
                            n = 2;
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (poll_reg > limit_reg)
                    begin
                        b.res[1] = mk(ACT_DONE, 8'd0, 8'd0, 1'b1);
                        n = 2;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        if (poll_reg != 16'hFFFF)
                            poll_next = poll_reg + 16'd1;
                        b.res[1] = mk(ACT_SEL, 8'd0, 8'd0, 1'b0);
                        b.res[2] = mk(ACT_SEND, CMD_RDSR, 8'd0, 1'b0);
                        b.res[3] = mk(ACT_RECV, 8'd0, 8'd0, 1'b0);
                        n = 4;
                    end
                end
            end
            default: ;
        endcase
        b.count = CntW'(n);
    end

    assign q_push = accept && (b.count != '0);
    assign q_data = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            op_reg <= 3'd0;
            addr_reg <= 24'd0;
            left_reg <= 24'd0;
            poll_reg <= 16'd0;
            step_reg <= 4'd0;
            limit_reg <= POLL_LIMIT_RESET;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (accept)
            begin
                phase_reg <= phase_next;
                op_reg <= op_next;
                addr_reg <= addr_next;
                left_reg <= left_next;
                poll_reg <= poll_next;
                step_reg <= step_next;
            end
        end
    end
endmodule

// ===== src/snc_back.sv =====
`include "spi_nor_command_sequencer_core_assert.svh"
module snc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_push,
    input  snc_pkg::batch_t q_data,
    output logic            q_full,
    snc_out_if.source       out_ch
);
    import snc_pkg::*;

    batch_t           mem [QDepth];
    logic [QPtrW-1:0] wr_reg, rd_reg;
    logic [QPtrW:0]   cnt_reg;
    logic [CntW-1:0]  idx_reg;
    batch_t           head;
    res_t             cur;
    logic             pop, fire;

    assign q_full = (cnt_reg == (QPtrW+1)'(QDepth));
    assign head = mem[rd_reg];
    assign cur = head.res[idx_reg];
    assign out_ch.valid = (cnt_reg != '0);
    assign out_ch.action = cur.action;
    assign out_ch.spi_byte = cur.spi_byte;
    assign out_ch.host_byte = cur.host_byte;
    assign out_ch.status = cur.status;
    assign out_ch.last = (idx_reg == head.count - CntW'(1));
    assign fire = out_ch.valid && out_ch.ready;
    assign pop = fire && out_ch.last;

    always_ff @(posedge clk)
    begin
        if (q_push)
            mem[wr_reg] <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (q_push)
                wr_reg <= wr_reg + QPtrW'(1);
            if (pop)
            begin
                rd_reg <= rd_reg + QPtrW'(1);
                idx_reg <= '0;
            end
            else if (fire)
                idx_reg <= idx_reg + CntW'(1);
            cnt_reg <= cnt_reg + (QPtrW+1)'(q_push) - (QPtrW+1)'(pop);
        end
    end

    `SNC_ASSERT(a_no_overflow, clk, rst_n, q_full |-> !q_push, "queue overflow")
    `SNC_ASSERT(a_idx_range, clk, rst_n, out_ch.valid |-> idx_reg < head.count,
        "result index past batch")
    `SNC_ASSERT(a_idx_idle, clk, rst_n, !out_ch.valid |-> idx_reg == '0, "stale index")
endmodule

// ===== src/spi_nor_command_sequencer_core.sv =====
// SPI NOR command sequencer: requests, host write bytes and flash receive bytes enter on
// in_ch, one per cycle while ready; each expands into up to 10 SPI actions on out_ch, one per
// cycle while out_ch is ready. A front stage decodes an item combinationally and pushes its
// action list into a 4-deep queue, and ready drops only when the queue is full; the back stage
// plays the lists out in order, an item's first action once the items ahead are played out.
// Write poll_limit only while idle.
module spi_nor_command_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    snc_in_if.sink      in_ch,
    snc_out_if.source   out_ch
);
    import snc_pkg::*;

    logic   q_push, q_full;
    batch_t q_data;

    snc_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch), .q_full(q_full), .q_push(q_push), .q_data(q_data)
    );

    snc_back u_back (
        .clk(clk), .rst_n(rst_n), .q_push(q_push), .q_data(q_data),
        .q_full(q_full), .out_ch(out_ch)
    );
endmodule

// ===== verif/snc_checker.sv =====
`timescale 1ns / 1ps

module snc_checker
    import snc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    snc_in_if           in_ch,
    snc_out_if          out_ch,
    output int          errors,
    output int          pending,
    output logic        seq_idle,
    output logic        seq_wants_host
);

    typedef struct packed {
        res_t r;
        logic last;
    } action_exp_t;

    action_exp_t action_q[$];
    res_t        step_acts[$];

    logic [15:0] poll_lim;
    phase_t      ph;
    logic [2:0]  cur_op;
    logic [23:0] addr_h;
    logic [23:0] left;
    logic [15:0] polls;
    logic [3:0]  resume;
    int          mism;

    assign pending        = action_q.size();
    assign seq_idle       = (ph == PH_IDLE);
    assign seq_wants_host = (ph == PH_DATA_OUT);
    assign errors         = mism;

    task automatic put(input act_t a, input logic [7:0] sb, input logic [7:0] hb,
                       input logic st);
        res_t r;
        r.action = a;
        r.spi_byte = sb;
        r.host_byte = hb;
        r.status = st;
        step_acts.push_back(r);
    endtask

    task automatic put_byte(input logic [7:0] b);
        put(ACT_SEND, b, 8'h00, 1'b0);
    endtask

    task automatic close_op(input logic st);
        put(ACT_DONE, 8'h00, 8'h00, st);
        ph = PH_IDLE;
    endtask

    task automatic lone_cmd(input logic [7:0] cmd);
        put(ACT_SEL, 8'h00, 8'h00, 1'b0);
        put_byte(cmd);
        put(ACT_DESEL, 8'h00, 8'h00, 1'b0);
    endtask

    task automatic put_addr(input logic [23:0] a);
        put_byte(a[23:16]);
        put_byte(a[15:8]);
        put_byte(a[7:0]);
    endtask

    task automatic open_poll(input logic [3:0] step);
        resume = step;
        polls = 16'd0;
        put(ACT_SEL, 8'h00, 8'h00, 1'b0);
        put_byte(CMD_RDSR);
        put(ACT_RECV, 8'h00, 8'h00, 1'b0);
        ph = PH_POLL;
    endtask

    // flash reported ready: carry on with the next step of the operation
    task automatic carry_on();
        case (cur_op)
            OP_READ:
            begin
                put(ACT_SEL, 8'h00, 8'h00, 1'b0);
                put_byte(CMD_READ);
                put_addr(addr_h);
                put(ACT_RECV, 8'h00, 8'h00, 1'b0);
                ph = PH_DATA_IN;
            end
            OP_SECTOR, OP_CHIP:
            begin
                if (resume == 0)
                begin
                    lone_cmd(CMD_WREN);
                    open_poll(4'd1);
                end
                else if (resume == 1)
                begin
                    put(ACT_SEL, 8'h00, 8'h00, 1'b0);
                    if (cur_op == OP_SECTOR)
                    begin
                        put_byte(CMD_SE);
                        put_addr(addr_h);
                    end
                    else
                    begin
                        put_byte(CMD_CE);
                    end
                    put(ACT_DESEL, 8'h00, 8'h00, 1'b0);
                    open_poll(4'd2);
                end
                else
                begin
                    close_op(1'b0);
                end
            end
            default:
            begin
                case (resume)
                    4'd0:
                    begin
                        lone_cmd(CMD_EWSR);
                        open_poll(4'd1);
                    end
                    4'd1:
                    begin
                        put(ACT_SEL, 8'h00, 8'h00, 1'b0);
                        put_byte(CMD_WRSR);
                        put_byte(BYTE_ZERO);
                        put(ACT_DESEL, 8'h00, 8'h00, 1'b0);
                        open_poll(4'd2);
                    end
                    4'd2:
                    begin
                        lone_cmd(CMD_WREN);
                        open_poll(4'd3);
                    end
                    4'd3:
                    begin
                        put(ACT_SEL, 8'h00, 8'h00, 1'b0);
                        put_byte(CMD_PP);
                        put_addr(addr_h);
                        ph = PH_DATA_OUT;
                    end
                    4'd4:
                    begin
                        lone_cmd(CMD_WRDI);
                        open_poll(4'd5);
                    end
                    default: close_op(1'b0);
                endcase
            end
        endcase
    endtask

    task automatic take_request(input logic [2:0] op, input logic [23:0] a,
                                input logic [23:0] len);
        if (ph != PH_IDLE || op > OP_ID)
            return;
        cur_op = op;
        addr_h = a;
        left = len;
        if ((op == OP_READ || op == OP_PROG) && left == 0)
        begin
            close_op(1'b0);
            return;
        end
        if (op == OP_ID)
        begin
            left = 24'(IdBytes);
            put(ACT_SEL, 8'h00, 8'h00, 1'b0);
            put_byte(CMD_RDID);
            put(ACT_RECV, 8'h00, 8'h00, 1'b0);
            ph = PH_DATA_IN;
            return;
        end
        if (op == OP_SECTOR)
            addr_h = a & ~((24'd1 << SectorBits) - 24'd1);
        open_poll(4'd0);
    endtask

    task automatic take_rx(input logic [7:0] b);
        if (ph == PH_POLL)
        begin
            put(ACT_DESEL, 8'h00, 8'h00, 1'b0);
            if (!b[0])
            begin
                carry_on();
            end
            else if (polls > poll_lim)
            begin
                close_op(1'b1);
            end
            else
            begin
                if (polls != 16'hFFFF)
                    polls++;
                put(ACT_SEL, 8'h00, 8'h00, 1'b0);
                put_byte(CMD_RDSR);
                put(ACT_RECV, 8'h00, 8'h00, 1'b0);
            end
        end
        else if (ph == PH_DATA_IN)
        begin
            put(ACT_HOST, 8'h00, b, 1'b0);
            if (left > 0)
                left--;
            if (left > 0)
            begin
                put(ACT_RECV, 8'h00, 8'h00, 1'b0);
            end
            else
            begin
                put(ACT_DESEL, 8'h00, 8'h00, 1'b0);
                close_op(1'b0);
            end
        end
    endtask

    task automatic take_host(input logic [7:0] b);
        if (ph != PH_DATA_OUT)
            return;
        put_byte(b);
        if (left > 0)
            left--;
        if (left == 0)
        begin
            put(ACT_DESEL, 8'h00, 8'h00, 1'b0);
            open_poll(4'd4);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        action_exp_t e;
        if (!rst_n)
        begin
            poll_lim <= POLL_LIMIT_RESET;
            ph = PH_IDLE;
            cur_op = 3'd0;
            addr_h = 24'd0;
            left = 24'd0;
            polls = 16'd0;
            resume = 4'd0;
            mism = 0;
            action_q.delete();
        end
        else
        begin
            if (cfg_we)
                poll_lim <= cfg_wdata;
            if (in_ch.valid && in_ch.ready)
            begin
                step_acts.delete();
                case (in_ch.mode)
                    MODE_REQ:  take_request(in_ch.operation, in_ch.address, in_ch.length);
                    MODE_HOST: take_host(in_ch.data_byte);
                    MODE_RX:   take_rx(in_ch.data_byte);
                    default:   ;
                endcase
                foreach (step_acts[i])
                begin
                    e.r = step_acts[i];
                    e.last = (i == step_acts.size() - 1);
                    action_q.push_back(e);
                end
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (action_q.size() == 0)
                begin
                    mism++;
                    if (mism <= 10)
                        $display("unexpected action %0d spi %h host %h st %b last %b",
                                 out_ch.action, out_ch.spi_byte, out_ch.host_byte,
                                 out_ch.status, out_ch.last);
                end
                else
                begin
                    e = action_q.pop_front();
                    if (out_ch.action !== e.r.action || out_ch.spi_byte !== e.r.spi_byte
                        || out_ch.host_byte !== e.r.host_byte
                        || out_ch.status !== e.r.status || out_ch.last !== e.last)
                    begin
                        mism++;
                        if (mism <= 10)
                        begin
                            $write("mismatch: exp act %0d spi %h host %h st %b last %b, ",
                                   e.r.action, e.r.spi_byte, e.r.host_byte, e.r.status,
                                   e.last);
                            $display("got act %0d spi %h host %h st %b last %b",
                                     out_ch.action, out_ch.spi_byte, out_ch.host_byte,
                                     out_ch.status, out_ch.last);
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import snc_pkg::*;

    localparam int StallLimit = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          errors;
    int          pending;
    logic        seq_idle;
    logic        seq_wants_host;
    int          burst_left;
    int          sent;
    int          busy_max;
    int          stall_cnt;
    int          rx_mode;
    int          rx_left;

    snc_in_if  in_ch();
    snc_out_if out_ch();

    spi_nor_command_sequencer_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    snc_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .errors        (errors),
        .pending       (pending),
        .seq_idle      (seq_idle),
        .seq_wants_host(seq_wants_host)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver: stall pattern switches between free flow, light and heavy stalls
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(16, 80);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(0, 4) != 0);
            default: out_ch.ready <= ($urandom_range(0, 2) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= StallLimit)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic push_item(input logic [1:0] m, input logic [2:0] op,
                             input logic [23:0] a, input logic [23:0] len,
                             input logic [7:0] b);
        in_ch.valid <= 1'b1;
        in_ch.mode <= m;
        in_ch.operation <= op;
        in_ch.address <= a;
        in_ch.length <= len;
        in_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        sent++;
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(0, 12);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // short lengths keep a stray request that starts an operation from running for long
    task automatic push_noise();
        push_item(2'($urandom_range(0, 3)), 3'($urandom), 24'($urandom),
                  24'($urandom_range(0, 8)), 8'($urandom));
    endtask

    // a step of a well-formed sequence, now and then preceded by a stray item
    task automatic push_step(input logic [1:0] m, input logic [7:0] b);
        if ($urandom_range(0, 24) == 0)
            push_noise();
        push_item(m, OP_READ, 24'($urandom), 24'($urandom), b);
    endtask

    task automatic await_ready();
        repeat ($urandom_range(0, busy_max)) push_step(MODE_RX, 8'($urandom) | 8'h01);
        push_step(MODE_RX, 8'($urandom) & 8'hFE);
    endtask

    task automatic run_op(input logic [2:0] op, input logic [23:0] a, input logic [23:0] len);
        push_item(MODE_REQ, op, a, len, 8'($urandom));
        case (op)
            OP_READ:
            begin
                if (len != 0)
                begin
                    await_ready();
                    repeat (len) push_step(MODE_RX, 8'($urandom));
                end
            end
            OP_PROG:
            begin
                if (len != 0)
                begin
                    repeat (3) await_ready();
                    repeat (len) push_step(MODE_HOST, 8'($urandom));
                    await_ready();
                end
            end
            OP_SECTOR, OP_CHIP: repeat (3) await_ready();
            OP_ID:              repeat (IdBytes) push_step(MODE_RX, 8'($urandom));
            default:            ;
        endcase
    endtask

    // push filler bytes until the sequencer is idle again, then let the queue empty
    task automatic settle(input int tail);
        while (!seq_idle)
        begin
            if (seq_wants_host)
                push_item(MODE_HOST, OP_READ, 24'd0, 24'd0, 8'($urandom));
            else
                push_item(MODE_RX, OP_READ, 24'd0, 24'd0, 8'h00);
        end
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    task automatic set_poll_limit(input logic [15:0] lim);
        settle(60);
        cfg_we <= 1'b1;
        cfg_wdata <= lim;
        @(negedge clk);
        cfg_we <= 1'b0;
        busy_max = (lim + 3 < 6) ? lim + 3 : 6;
    endtask

    task automatic run_random(input int count);
        int    stop_at;
        int    pick;
        logic [2:0] op;
        stop_at = sent + count;
        while (sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            op = 3'($urandom_range(0, 4));
            if (pick < 80)
            begin
                if (op == OP_READ || op == OP_PROG)
                    run_op(op, 24'($urandom),
                           ($urandom_range(0, 9) == 0) ? 24'd0 : 24'($urandom_range(1, 6)));
                else
                    run_op(op, 24'($urandom), 24'($urandom_range(0, 24'h800000)));
            end
            else if (pick < 95)
            begin
                push_noise();
            end
            else
            begin
                settle(0);
            end
        end
    endtask

    initial
    begin
        logic [15:0] limits [6];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 16'd0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_REQ;
        in_ch.operation = OP_READ;
        in_ch.address = 24'd0;
        in_ch.length = 24'd0;
        in_ch.data_byte = 8'd0;
        out_ch.ready = 1'b0;
        rx_mode = 0;
        rx_left = 0;
        stall_cnt = 0;
        burst_left = 0;
        sent = 0;
        busy_max = 6;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, every operation, ignored items
        run_op(OP_READ, 24'hFFFFFF, 24'd1);
        run_op(OP_READ, 24'h000000, 24'd0);
        run_op(OP_PROG, 24'h000000, 24'd0);
        run_op(OP_PROG, 24'hFFFFFF, 24'd2);
        run_op(OP_SECTOR, 24'hFFFFFF, 24'h800000);
        run_op(OP_CHIP, 24'h000000, 24'hFFFFFF);
        run_op(OP_ID, 24'h000000, 24'd0);
        push_item(MODE_REQ, 3'd5, 24'h0, 24'd1, 8'h00);
        push_item(MODE_REQ, 3'd7, 24'hFFFFFF, 24'd1, 8'hFF);
        push_item(MODE_NONE, OP_READ, 24'h0, 24'd0, 8'hFF);
        push_item(MODE_HOST, OP_READ, 24'h0, 24'd0, 8'h55);
        push_item(MODE_RX, OP_READ, 24'h0, 24'd0, 8'hAA);
        // request while busy is dropped
        push_item(MODE_REQ, OP_CHIP, 24'h0, 24'd0, 8'h00);
        push_item(MODE_REQ, OP_ID, 24'h0, 24'd0, 8'h00);
        settle(0);

        limits = '{16'd0, 16'd1, 16'd65535, 16'($urandom), 16'd3, 16'd10000};
        foreach (limits[i])
        begin
            set_poll_limit(limits[i]);
            run_random(25);
            settle(0);
            run_random(25);
        end

        settle(60);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
